/* rtl/eia_pkg.sv */
// ----------------------------------------------------------------------------
// eia_pkg
// Shared types, operation codes and sizes for the integer ALU with floor
// division.
// ----------------------------------------------------------------------------
package eia_pkg;

   localparam int DATA_WIDTH      = 64;
   localparam int VALUE_WIDTH_DEF = 64;
   localparam int OP_WIDTH        = 4;

   localparam logic [OP_WIDTH-1:0] OP_ADD  = 4'd0;
   localparam logic [OP_WIDTH-1:0] OP_SUB  = 4'd1;
   localparam logic [OP_WIDTH-1:0] OP_MUL  = 4'd2;
   localparam logic [OP_WIDTH-1:0] OP_MAX  = 4'd3;
   localparam logic [OP_WIDTH-1:0] OP_MIN  = 4'd4;
   localparam logic [OP_WIDTH-1:0] OP_DIV  = 4'd5;
   localparam logic [OP_WIDTH-1:0] OP_FDIV = 4'd6;
   localparam logic [OP_WIDTH-1:0] OP_FMOD = 4'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MAG1,
      ST_MAG2,
      ST_DIV,
      ST_MUL,
      ST_FIX,
      ST_OUT
   } eia_state_type;

   typedef struct packed {
      logic ready;
      logic done;
      logic no_value;
   } eia_status_type;

endpackage

/* rtl/eia_req_if.sv */
// ----------------------------------------------------------------------------
// eia_req_if
// Operand channel: valid/ready with one operand pair per transfer.
// ----------------------------------------------------------------------------
interface eia_req_if;
   import eia_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] left_value;
   logic signed [DATA_WIDTH-1:0] right_value;
   logic                         left_fixed;
   logic                         right_fixed;
   logic                         last_element;

   modport source (
      output valid, left_value, right_value, left_fixed, right_fixed, last_element,
      input  ready
   );
   modport sink (
      input  valid, left_value, right_value, left_fixed, right_fixed, last_element,
      output ready
   );
endinterface

/* rtl/eia_rsp_if.sv */
// ----------------------------------------------------------------------------
// eia_rsp_if
// Result channel: valid/ready with one result per transfer.
// ----------------------------------------------------------------------------
interface eia_rsp_if;
   import eia_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] result_value;
   logic                         result_fixed;
   logic                         no_value;
   logic                         row_failed;
   logic                         row_end;

   modport source (
      output valid, result_value, result_fixed, no_value, row_failed, row_end,
      input  ready
   );
   modport sink (
      input  valid, result_value, result_fixed, no_value, row_failed, row_end,
      output ready
   );
endinterface

/* rtl/eia_csr_if.sv */
// ----------------------------------------------------------------------------
// eia_csr_if
// Configuration write channel for the operation register.
// ----------------------------------------------------------------------------
interface eia_csr_if;
   import eia_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_WIDTH-1:0] operation;

   modport source (output valid, operation, input ready);
   modport sink   (input valid, operation, output ready);
endinterface

/* rtl/eia_core.sv */
// ----------------------------------------------------------------------------
// eia_core
// Sequencer around one shared (W+1)-bit adder: add/sub/compare, operand magnitudes,
// shift-add multiply, restoring divide and the final sign fix-up.
// ----------------------------------------------------------------------------
module eia_core #(
   parameter int VALUE_WIDTH = eia_pkg::VALUE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           take,
   input  logic [eia_pkg::OP_WIDTH-1:0]   operation,
   input  logic [VALUE_WIDTH-1:0]         left,
   input  logic [VALUE_WIDTH-1:0]         right,
   output eia_pkg::eia_status_type        status,
   output logic [VALUE_WIDTH-1:0]         value
);
   import eia_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int CW = $clog2(VALUE_WIDTH);
   localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

   eia_state_type state_ff, state_in;

   logic [W-1:0]  a_ff, a_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  q_ff, q_in;
   logic [W-1:0]  mb_ff, mb_in;
   logic [W:0]    acc_ff, acc_in;
   logic [W-1:0]  res_ff, res_in;
   logic          nv_ff, nv_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [W:0]   add_a, add_b, sum;
   logic         add_inv, add_cin;

   logic         sa, sb, diff;
   logic         is_mul, is_div, is_simple;
   logic         div_err, rem_zero, mul_ovf, last_step;
   logic [W-1:0] mag1_src, mag2_src;
   logic [W:0]   shift_rem;

   assign sa   = a_ff[W-1];
   assign sb   = b_ff[W-1];
   assign diff = sa ^ sb;

   assign is_mul    = (operation == OP_MUL);
   assign is_div    = (operation == OP_DIV) || (operation == OP_FDIV) ||
                      (operation == OP_FMOD);
   assign is_simple = (operation == OP_ADD) || (operation == OP_SUB) ||
                      (operation == OP_MAX) || (operation == OP_MIN);

   assign div_err   = (b_ff == '0) ||
                      ((a_ff == MIN_VAL) && (b_ff == '1) && (operation != OP_FMOD));
   assign rem_zero  = (acc_ff[W-1:0] == '0);
   assign mul_ovf   = (acc_ff[W-1:0] != '0) ||
                      (q_ff[W-1] && !(diff && (q_ff[W-2:0] == '0)));
   assign last_step = (cnt_ff == CW'(W - 1));

   assign mag1_src  = is_mul ? b_ff : a_ff;
   assign mag2_src  = is_mul ? a_ff : b_ff;
   assign shift_rem = {acc_ff[W-1:0], q_ff[W-1]};

   // shared adder
   assign sum = add_a + (add_inv ? ~add_b : add_b) + (W+1)'(add_cin);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (is_mul || (is_div && !div_err)) begin
               state_in = ST_MAG1;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_MAG1: state_in = ST_MAG2;
         ST_MAG2: state_in = is_mul ? ST_MUL : ST_DIV;
         ST_DIV, ST_MUL: begin
            if (last_step) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: state_in = ST_OUT;
         ST_OUT: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_inv = 1'b0;
      add_cin = 1'b0;
      case (state_ff)
         ST_DECODE: begin
            add_a   = {a_ff[W-1], a_ff};
            add_b   = {b_ff[W-1], b_ff};
            add_inv = (operation != OP_ADD);
            add_cin = (operation != OP_ADD);
         end
         ST_MAG1: begin
            add_b   = {1'b0, mag1_src};
            add_inv = mag1_src[W-1];
            add_cin = mag1_src[W-1];
         end
         ST_MAG2: begin
            add_b   = {1'b0, mag2_src};
            add_inv = mag2_src[W-1];
            add_cin = mag2_src[W-1];
         end
         ST_DIV: begin
            add_a   = shift_rem;
            add_b   = {1'b0, mb_ff};
            add_inv = 1'b1;
            add_cin = 1'b1;
         end
         ST_MUL: begin
            add_a = acc_ff;
            add_b = q_ff[0] ? {1'b0, mb_ff} : '0;
         end
         ST_FIX: begin
            case (operation)
               OP_FMOD: begin
                  add_a   = diff ? {b_ff[W-1], b_ff} : '0;
                  add_b   = {1'b0, acc_ff[W-1:0]};
                  add_inv = sa;
                  add_cin = sa;
               end
               OP_FDIV: begin
                  add_b   = {1'b0, q_ff};
                  add_inv = diff;
                  add_cin = diff && rem_zero;
               end
               default: begin
                  add_b   = {1'b0, q_ff};
                  add_inv = diff;
                  add_cin = diff;
               end
            endcase
         end
         default: begin
            add_a = '0;
         end
      endcase
   end

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      q_in   = q_ff;
      mb_in  = mb_ff;
      acc_in = acc_ff;
      res_in = res_ff;
      nv_in  = nv_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               a_in = left;
               b_in = right;
            end
         end
         ST_DECODE: begin
            cnt_in = '0;
            acc_in = '0;
            nv_in  = 1'b0;
            res_in = '0;
            if (is_simple) begin
               case (operation)
                  OP_MAX: res_in = sum[W] ? b_ff : a_ff;
                  OP_MIN: res_in = sum[W] ? a_ff : b_ff;
                  default: begin
                     nv_in  = sum[W] ^ sum[W-1];
                     res_in = (sum[W] ^ sum[W-1]) ? '0 : sum[W-1:0];
                  end
               endcase
            end else if (is_div) begin
               nv_in = div_err;
            end else if (!is_mul) begin
               nv_in = 1'b1;
            end
         end
         ST_MAG1: q_in  = sum[W-1:0];
         ST_MAG2: mb_in = sum[W-1:0];
         ST_DIV: begin
            acc_in = sum[W] ? shift_rem : sum;
            q_in   = {q_ff[W-2:0], ~sum[W]};
            cnt_in = cnt_ff + 1'b1;
         end
         ST_MUL: begin
            acc_in = {1'b0, sum[W:1]};
            q_in   = {sum[0], q_ff[W-1:1]};
            cnt_in = cnt_ff + 1'b1;
         end
         ST_FIX: begin
            if (is_mul) begin
               nv_in  = mul_ovf;
               res_in = mul_ovf ? '0 : sum[W-1:0];
            end else if (operation == OP_FMOD) begin
               res_in = rem_zero ? '0 : sum[W-1:0];
            end else begin
               res_in = sum[W-1:0];
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      q_ff   <= q_in;
      mb_ff  <= mb_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
      nv_ff  <= nv_in;
      cnt_ff <= cnt_in;
   end

   assign status.ready    = (state_ff == ST_IDLE);
   assign status.done     = (state_ff == ST_OUT) && take;
   assign status.no_value = nv_ff;
   assign value           = res_ff;

endmodule

/* rtl/exact_int_alu_with_floor_division.sv */
// ----------------------------------------------------------------------------
// exact_int_alu_with_floor_division
// Signed ALU: add, sub, mul, max, min, truncating/floor divide, floor modulo.
// Path: add/sub/max/min, divide errors and unsupported codes go from decode
//   to the result register; mul and div/mod also pass magnitude, loop, fix-up.
// Throughput: one pair in flight; a result stall also holds the next transfer.
//   Reset: synchronous; op to add, row state, valid.
// ----------------------------------------------------------------------------
module exact_int_alu_with_floor_division #(
   parameter int VALUE_WIDTH = eia_pkg::VALUE_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   eia_req_if.sink    req_if,
   eia_rsp_if.source  rsp_if,
   eia_csr_if.sink    csr_if
);
   import eia_pkg::*;

   logic [OP_WIDTH-1:0]   op_ff, op_in;
   logic                  fixed_ff, fixed_in;
   logic                  last_ff, last_in;
   logic                  row_seen_ff, row_seen_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_fixed_ff, rsp_fixed_in;
   logic                  rsp_nv_ff, rsp_nv_in;
   logic                  rsp_failed_ff, rsp_failed_in;
   logic                  rsp_end_ff, rsp_end_in;

   eia_status_type         status;
   logic [VALUE_WIDTH-1:0] core_value;
   logic                   accept, take, failed;

   assign accept        = req_if.valid && req_if.ready;
   assign take          = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = status.ready;
   assign csr_if.ready  = 1'b1;
   assign failed        = row_seen_ff || status.no_value;

   eia_core #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .take      (take),
      .operation (op_ff),
      .left      (req_if.left_value[VALUE_WIDTH-1:0]),
      .right     (req_if.right_value[VALUE_WIDTH-1:0]),
      .status    (status),
      .value     (core_value)
   );

   always_comb begin
      op_in         = op_ff;
      fixed_in      = fixed_ff;
      last_in       = last_ff;
      row_seen_in   = row_seen_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_fixed_in  = rsp_fixed_ff;
      rsp_nv_in     = rsp_nv_ff;
      rsp_failed_in = rsp_failed_ff;
      rsp_end_in    = rsp_end_ff;
      if (csr_if.valid) begin
         op_in = csr_if.operation;
      end
      if (accept) begin
         fixed_in = req_if.left_fixed && req_if.right_fixed;
         last_in  = req_if.last_element;
      end
      if (status.done) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = DATA_WIDTH'($signed(core_value));
         rsp_fixed_in  = fixed_ff;
         rsp_nv_in     = status.no_value;
         rsp_failed_in = failed;
         rsp_end_in    = last_ff;
         row_seen_in   = last_ff ? 1'b0 : failed;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= OP_ADD;
         row_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         op_ff        <= op_in;
         row_seen_ff  <= row_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fixed_ff      <= fixed_in;
      last_ff       <= last_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_fixed_ff  <= rsp_fixed_in;
      rsp_nv_ff     <= rsp_nv_in;
      rsp_failed_ff <= rsp_failed_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.result_value = rsp_value_ff;
   assign rsp_if.result_fixed = rsp_fixed_ff;
   assign rsp_if.no_value     = rsp_nv_ff;
   assign rsp_if.row_failed   = rsp_failed_ff;
   assign rsp_if.row_end      = rsp_end_ff;

endmodule

/* tb/exact_int_alu_with_floor_division_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exact_int_alu_with_floor_division_test
// Self-checking bench for the signed integer ALU. A directed table covers the
// operand extremes, all defined op codes, overflow, divide by zero and the
// minimum over minus one, then random phases sweep every operation setting.
// A built-in predictor checks each result field, including the row failure
// tracking. Both channels idle at random, and the result side holds off once
// for a long stretch so that the block stalls its operand input.
// ----------------------------------------------------------------------------
module exact_int_alu_with_floor_division_test;
   import eia_pkg::*;

   localparam logic signed [63:0] S_MIN  = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] S_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S_NEG1 = -64'sd1;
   localparam logic [OP_WIDTH-1:0] OP_UNSUP_LO = 4'd8;
   localparam logic [OP_WIDTH-1:0] OP_UNSUP_HI = 4'd15;
   localparam int IDLE_LIMIT    = 5000;
   localparam int DRAIN_CYCLES  = 80;
   localparam int HOLD_CYCLES   = 600;
   localparam int HOLD_AT       = 300;
   localparam int PHASES        = 24;
   localparam int PHASE_ITEMS   = 64;
   localparam int UNSUP_ITEMS   = 8;

   typedef struct packed {
      logic signed [63:0] left_value;
      logic signed [63:0] right_value;
      logic               left_fixed;
      logic               right_fixed;
      logic               last_element;
   } operand_pair_type;

   typedef struct packed {
      logic signed [63:0] result_value;
      logic               result_fixed;
      logic               no_value;
      logic               row_failed;
      logic               row_end;
   } alu_result_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0] op;
      operand_pair_type    pair;
      logic                typed;
      logic                typed_nv;
      logic signed [63:0]  typed_value;
   } stim_row_type;

   logic clock;
   logic reset;

   eia_req_if req ();
   eia_rsp_if rsp ();
   eia_csr_if csr ();

   exact_int_alu_with_floor_division u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp),
      .csr_if (csr)
   );

   alu_result_type      pending_results[$];
   stim_row_type        directed_rows[$];
   logic [OP_WIDTH-1:0] active_op;
   logic                row_failure_seen;
   int                  mismatches;
   bit                  send_burst;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // exact value of one operation; ok is low when no value can be given
   function automatic logic signed [63:0] alu_value(input logic [OP_WIDTH-1:0] op,
                                                    input logic signed [63:0] a,
                                                    input logic signed [63:0] b,
                                                    output logic ok);
      logic signed [127:0] wa;
      logic signed [127:0] wb;
      logic signed [127:0] wide;
      logic signed [127:0] q;
      logic signed [127:0] r;
      wa = a;
      wb = b;
      wide = '0;
      ok = 1'b1;
      case (op)
         OP_ADD: wide = wa + wb;
         OP_SUB: wide = wa - wb;
         OP_MUL: wide = wa * wb;
         OP_MAX: wide = (a >= b) ? wa : wb;
         OP_MIN: wide = (a <= b) ? wa : wb;
         OP_DIV, OP_FDIV, OP_FMOD: begin
            if (b == 0) begin
               ok = 1'b0;
            end else begin
               q = wa / wb;
               r = wa % wb;
               if (op != OP_DIV && r != 0 && ((r < 0) != (b < 0))) begin
                  q = q - 1;
                  r = r + wb;
               end
               wide = (op == OP_FMOD) ? r : q;
            end
         end
         default: ok = 1'b0;
      endcase
      if (wide[127:63] != {65{wide[63]}})
         ok = 1'b0;
      return ok ? wide[63:0] : 64'sd0;
   endfunction

   function automatic alu_result_type track_row(input operand_pair_type p, input logic ok,
                                                input logic signed [63:0] v);
      alu_result_type res;
      res.result_value = ok ? v : 64'sd0;
      res.result_fixed = p.left_fixed & p.right_fixed;
      res.no_value     = ~ok;
      res.row_failed   = row_failure_seen | ~ok;
      res.row_end      = p.last_element;
      row_failure_seen = p.last_element ? 1'b0 : res.row_failed;
      return res;
   endfunction

   function automatic logic signed [63:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return S_MIN;
         1: return S_MAX;
         2: return 64'sd0;
         3: return S_NEG1;
         4: return 64'sd1;
         5: return 64'($signed(32'($urandom_range(0, 40)) - 32'sd20));
         6: return 64'($signed($urandom()));
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic operand_pair_type rand_pair();
      operand_pair_type p;
      p.left_value   = rand_operand();
      p.right_value  = rand_operand();
      p.left_fixed   = 1'($urandom_range(0, 1));
      p.right_fixed  = 1'($urandom_range(0, 1));
      p.last_element = ($urandom_range(0, 3) == 0);
      return p;
   endfunction

   task automatic add_row(input logic [OP_WIDTH-1:0] op, input logic signed [63:0] a,
                          input logic signed [63:0] b, input int lf, input int rf,
                          input int last, input int typed, input int tnv,
                          input logic signed [63:0] tval);
      stim_row_type row;
      row.op          = op;
      row.pair        = '{a, b, 1'(lf), 1'(rf), 1'(last)};
      row.typed       = 1'(typed);
      row.typed_nv    = 1'(tnv);
      row.typed_value = tval;
      directed_rows   = {directed_rows, row};
   endtask

   task automatic send_pair(input operand_pair_type p, input logic typed, input logic tnv,
                            input logic signed [63:0] tval);
      int unsigned gap;
      logic ok;
      logic signed [63:0] v;
      alu_result_type res;
      gap = send_burst ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         @(negedge clock);
         req.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req.valid        <= 1'b1;
      req.left_value   <= p.left_value;
      req.right_value  <= p.right_value;
      req.left_fixed   <= p.left_fixed;
      req.right_fixed  <= p.right_fixed;
      req.last_element <= p.last_element;
      do @(posedge clock); while (req.ready !== 1'b1);
      if (typed) begin
         ok = ~tnv;
         v  = tval;
      end else begin
         v = alu_value(active_op, p.left_value, p.right_value, ok);
      end
      res = track_row(p, ok, v);
      pending_results = {pending_results, res};
   endtask

   // operation changes only with the block drained
   task automatic set_operation(input logic [OP_WIDTH-1:0] op);
      @(negedge clock);
      req.valid <= 1'b0;
      wait (pending_results.size() == 0);
      @(negedge clock);
      csr.valid     <= 1'b1;
      csr.operation <= op;
      do @(posedge clock); while (csr.ready !== 1'b1);
      active_op = op;
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      alu_result_type e;
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual %h", $time,
                     rsp.result_value);
         end else begin
            e = pending_results.pop_front();
            check_field("result_value", e.result_value, rsp.result_value);
            check_field("result_fixed", 64'(e.result_fixed), 64'(rsp.result_fixed));
            check_field("no_value", 64'(e.no_value), 64'(rsp.no_value));
            check_field("row_failed", 64'(e.row_failed), 64'(rsp.row_failed));
            check_field("row_end", 64'(e.row_end), 64'(rsp.row_end));
         end
      end
   end

   // result side ready, with one long hold-off
   initial begin
      int unsigned gap;
      int          seen;
      bit          burst;
      seen  = 0;
      burst = 1'b0;
      rsp.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (seen % 32 == 0)
            burst = ($urandom_range(0, 3) == 0);
         gap = burst ? 0 : $urandom_range(0, 13);
         if (seen == HOLD_AT)
            gap = HOLD_CYCLES;
         if (gap != 0) begin
            @(negedge clock);
            rsp.ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp.ready <= 1'b1;
         do @(posedge clock); while (rsp.valid !== 1'b1);
         seen++;
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req.valid === 1'b1 && req.ready === 1'b1) ||
             (rsp.valid === 1'b1 && rsp.ready === 1'b1) ||
             (csr.valid === 1'b1 && csr.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      logic [OP_WIDTH-1:0] op;
      int                  count;
      reset            = 1'b1;
      req.valid        = 1'b0;
      req.left_value   = '0;
      req.right_value  = '0;
      req.left_fixed   = 1'b0;
      req.right_fixed  = 1'b0;
      req.last_element = 1'b0;
      csr.valid        = 1'b0;
      csr.operation    = OP_ADD;
      active_op        = OP_ADD;
      row_failure_seen = 1'b0;
      mismatches       = 0;
      send_burst       = 1'b0;

      //      op           left    right   lf rf last typed nv  value
      add_row(OP_ADD,      64'sd1, 64'sd2, 1, 1, 0,   1,    0,  64'sd3);
      add_row(OP_ADD,      S_MAX,  64'sd1, 1, 0, 0,   1,    1,  64'sd0);
      add_row(OP_ADD,      S_MIN,  S_NEG1, 0, 1, 1,   1,    1,  64'sd0);
      add_row(OP_ADD,      S_MAX,  S_MIN,  1, 1, 0,   1,    0,  S_NEG1);
      add_row(OP_SUB,      S_MIN,  64'sd1, 0, 0, 0,   1,    1,  64'sd0);
      add_row(OP_SUB,      64'sd0, S_MIN,  1, 1, 1,   1,    1,  64'sd0);
      add_row(OP_SUB,      S_MAX,  S_MAX,  1, 1, 0,   1,    0,  64'sd0);
      add_row(OP_MUL,      S_MIN,  64'sd1, 1, 1, 0,   1,    0,  S_MIN);
      add_row(OP_MUL,      S_MIN,  S_NEG1, 0, 1, 0,   1,    1,  64'sd0);
      add_row(OP_MUL,      S_MAX,  S_MAX,  1, 0, 1,   1,    1,  64'sd0);
      add_row(OP_MUL,      -64'sd3, 64'sd5, 1, 1, 0,  0,    0,  64'sd0);
      add_row(OP_MAX,      S_MIN,  S_MAX,  1, 1, 0,   1,    0,  S_MAX);
      add_row(OP_MIN,      S_MIN,  S_MAX,  0, 0, 1,   1,    0,  S_MIN);
      add_row(OP_DIV,      64'sd7, 64'sd0, 1, 1, 0,   1,    1,  64'sd0);
      add_row(OP_DIV,      S_MIN,  S_NEG1, 1, 1, 0,   1,    1,  64'sd0);
      add_row(OP_DIV,      -64'sd7, 64'sd2, 1, 0, 1,  0,    0,  64'sd0);
      add_row(OP_FDIV,     -64'sd7, 64'sd2, 1, 1, 0,  0,    0,  64'sd0);
      add_row(OP_FDIV,     S_MIN,  S_NEG1, 0, 1, 0,   1,    1,  64'sd0);
      add_row(OP_FDIV,     64'sd5, 64'sd0, 1, 1, 1,   1,    1,  64'sd0);
      add_row(OP_FMOD,     S_MIN,  S_NEG1, 1, 1, 0,   1,    0,  64'sd0);
      add_row(OP_FMOD,     -64'sd7, 64'sd2, 1, 1, 0,  0,    0,  64'sd0);
      add_row(OP_FMOD,     64'sd7, 64'sd0, 0, 1, 1,   1,    1,  64'sd0);
      add_row(OP_UNSUP_LO, 64'sd1, 64'sd1, 1, 1, 0,   1,    1,  64'sd0);
      add_row(OP_UNSUP_HI, S_MAX,  S_MIN,  1, 1, 1,   1,    1,  64'sd0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].op != active_op)
            set_operation(directed_rows[i].op);
         send_pair(directed_rows[i].pair, directed_rows[i].typed,
                   directed_rows[i].typed_nv, directed_rows[i].typed_value);
      end

      for (int p = 0; p < PHASES; p++) begin
         op = (p < 16) ? OP_WIDTH'(p) : OP_WIDTH'($urandom_range(0, 7));
         set_operation(op);
         send_burst = ($urandom_range(0, 3) == 0);
         count = (op >= OP_UNSUP_LO) ? UNSUP_ITEMS : PHASE_ITEMS;
         repeat (count) send_pair(rand_pair(), 1'b0, 1'b0, 64'sd0);
      end

      @(negedge clock);
      req.valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
